### design/accel_average_scale_clamp_core_assert.svh
// Assertion macros shared by the core's modules.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef ACCEL_AVERAGE_SCALE_CLAMP_CORE_ASSERT_SVH
`define ACCEL_AVERAGE_SCALE_CLAMP_CORE_ASSERT_SVH

// Same-cycle implication.
`define AASC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define AASC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/aasc_pkg.sv
`timescale 1ns / 1ps
package aasc_pkg;

	localparam int WORD_W    = 16;
	localparam int SAMPLE_SH = 4;
	localparam int SUM_W     = 20;
	localparam int COUNT_W   = 8;
	localparam int SENS_W    = 11;
	localparam int LEVEL_W   = 6;
	localparam int AXES      = 3;
	localparam int AXIS_W    = 2;
	localparam int AVG_W     = 12;
	localparam int SCALE_SH  = 5;
	localparam int DIV_CNT_W = 5;

	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 24;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY  = 2'd1;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 8'd8;
	localparam logic [SENS_W-1:0]  SENS_RESET  = 11'd1024;

	localparam logic [LEVEL_W-1:0] LEVEL_ZERO = 6'd32;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 6'd63;
	localparam logic [LEVEL_W-1:0] LEVEL_MIN  = 6'd0;

	localparam logic [AXIS_W-1:0] AXIS_LAST = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AVG_START,
		ST_AVG_WAIT,
		ST_SCL_START,
		ST_SCL_WAIT,
		ST_LOAD
	} aasc_state_t;

	typedef struct packed {
		logic              acc_en;
		logic              div_start;
		logic              div_scale;
		logic              store_level;
		logic              load_out;
		logic [AXIS_W-1:0] axis;
	} aasc_cmd_t;

	typedef struct packed {
		logic last_sample;
		logic div_done;
		logic out_free;
	} aasc_sts_t;

endpackage

### design/aasc_div.sv
`timescale 1ns / 1ps
module aasc_div
	import aasc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SUM_W-1:0]  dividend,
	input  logic [SENS_W-1:0] divisor,
	output logic              done,
	output logic [SUM_W-1:0]  quotient
);

	localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(SUM_W - 1);

	logic [SUM_W-1:0]     dvd_q;
	logic [SENS_W-1:0]    rem_q;
	logic [SENS_W-1:0]    divr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [SENS_W:0]      trial;
	logic [SENS_W:0]      diff;
	logic                 fits;

	// Restoring step: one quotient bit per cycle, MSB first.
	assign trial = {rem_q, dvd_q[SUM_W-1]};
	assign fits  = trial >= {1'b0, divr_q};
	assign diff  = trial - {1'b0, divr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= dividend;
			rem_q  <= '0;
			divr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SUM_W-2:0], fits};
			rem_q <= fits ? diff[SENS_W-1:0] : trial[SENS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

### design/aasc_dp.sv
`timescale 1ns / 1ps
module aasc_dp
	import aasc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  aasc_cmd_t             cmd,
	output aasc_sts_t             sts,
	input  logic [S_DATA_W-1:0]   s_tdata,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_DATA_W-1:0]   m_tdata
);

	logic [COUNT_W-1:0]              count_q;
	logic [SENS_W-1:0]               sens_q;
	logic [AXES-1:0][SUM_W-1:0]      sum_q;
	logic [COUNT_W-1:0]              taken_q;
	logic [AXES-1:0][LEVEL_W-1:0]    level_q;
	logic [M_DATA_W-1:0]             out_data_q;
	logic                            out_valid_q;

	logic [AXES-1:0][SUM_W-1:0]      sample;
	logic [COUNT_W-1:0]              target;
	logic [SENS_W-1:0]               sens_eff;
	logic [SUM_W-1:0]                cur_sum;
	logic                            cur_neg;
	logic [SUM_W-1:0]                cur_mag;
	logic [SUM_W-1:0]                div_dividend;
	logic [SENS_W-1:0]               div_divisor;
	logic                            div_done;
	logic [SUM_W-1:0]                div_quo;
	logic [LEVEL_W-1:0]              level_next;

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			sample[a] = {{(SUM_W-AVG_W){s_tdata[a*WORD_W + WORD_W-1]}},
				s_tdata[a*WORD_W + SAMPLE_SH +: AVG_W]};
		end
	end

	// A zero register value behaves as one.
	assign target   = (count_q == '0) ? COUNT_W'(1) : count_q;
	assign sens_eff = (sens_q == '0) ? SENS_W'(1) : sens_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
			sens_q  <= SENS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SAMPLE_COUNT: count_q <= cfg_data[COUNT_W-1:0];
				CFG_SENSITIVITY:  sens_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			taken_q <= '0;
		end else if (cmd.load_out) begin
			sum_q   <= '0;
			taken_q <= '0;
		end else if (cmd.acc_en) begin
			for (int a = 0; a < AXES; a++) begin
				sum_q[a] <= sum_q[a] + sample[a];
			end
			taken_q <= taken_q + 1'b1;
		end
	end

	assign cur_sum = sum_q[cmd.axis];
	assign cur_neg = cur_sum[SUM_W-1];
	assign cur_mag = cur_neg ? (~cur_sum + 1'b1) : cur_sum;

	// Average pass divides |sum| by samples taken; scale pass divides 32*|avg| by sensitivity.
	always_comb begin
		if (cmd.div_scale) begin
			div_dividend = {{(SUM_W-AVG_W-SCALE_SH){1'b0}}, div_quo[AVG_W-1:0],
				{SCALE_SH{1'b0}}};
			div_divisor  = sens_eff;
		end else begin
			div_dividend = cur_mag;
			div_divisor  = {{(SENS_W-COUNT_W){1'b0}}, taken_q};
		end
	end

	aasc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		if (cur_neg) begin
			level_next = (div_quo >= SUM_W'(LEVEL_ZERO)) ? LEVEL_MIN
				: LEVEL_ZERO - div_quo[LEVEL_W-1:0];
		end else begin
			level_next = (div_quo >= SUM_W'(LEVEL_MAX - LEVEL_ZERO)) ? LEVEL_MAX
				: LEVEL_ZERO + div_quo[LEVEL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store_level) begin
			level_q[cmd.axis] <= level_next;
		end
		if (cmd.load_out) begin
			out_data_q <= {{(M_DATA_W-AXES*LEVEL_W){1'b0}}, level_q[2], level_q[1], level_q[0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.last_sample = ({1'b0, taken_q} + 9'd1) >= {1'b0, target};
	assign sts.div_done    = div_done;
	assign sts.out_free    = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`include "accel_average_scale_clamp_core_assert.svh"

	`AASC_ASSERT_NOW(a_taken_no_wrap, cmd.acc_en, taken_q != '1, "sample counter about to wrap")
	`AASC_ASSERT_NEXT(a_load_clears, cmd.load_out, (taken_q == '0) && out_valid_q, "load did not clear block")

endmodule

### design/aasc_ctrl.sv
`timescale 1ns / 1ps
module aasc_ctrl
	import aasc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  aasc_sts_t sts,
	output aasc_cmd_t cmd
);

	aasc_state_t       state_q;
	aasc_state_t       state_next;
	logic [AXIS_W-1:0] axis_q;
	logic [AXIS_W-1:0] axis_next;

	always_comb begin
		state_next = state_q;
		axis_next  = axis_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid && sts.last_sample) begin
					state_next = ST_AVG_START;
					axis_next  = '0;
				end
			end
			ST_AVG_START: state_next = ST_AVG_WAIT;
			ST_AVG_WAIT: begin
				if (sts.div_done) state_next = ST_SCL_START;
			end
			ST_SCL_START: state_next = ST_SCL_WAIT;
			ST_SCL_WAIT: begin
				if (sts.div_done) begin
					if (axis_q == AXIS_LAST) begin
						state_next = ST_LOAD;
					end else begin
						state_next = ST_AVG_START;
						axis_next  = axis_q + 1'b1;
					end
				end
			end
			ST_LOAD: begin
				if (sts.out_free) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd             = '0;
		cmd.axis        = axis_q;
		s_tready        = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.acc_en = s_tvalid;
			end
			ST_AVG_START: cmd.div_start = 1'b1;
			ST_SCL_START: begin
				cmd.div_start = 1'b1;
				cmd.div_scale = 1'b1;
			end
			ST_SCL_WAIT: cmd.store_level = sts.div_done;
			ST_LOAD:     cmd.load_out    = sts.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= '0;
		end else begin
			state_q <= state_next;
			axis_q  <= axis_next;
		end
	end

`include "accel_average_scale_clamp_core_assert.svh"

	`AASC_ASSERT_NOW(a_done_when_waiting, sts.div_done, (state_q == ST_AVG_WAIT) || (state_q == ST_SCL_WAIT), "divider finished outside a wait state")
	`AASC_ASSERT_NOW(a_axis_range, state_q != ST_IDLE, axis_q <= AXIS_LAST, "axis index out of range")

endmodule

### design/accel_average_scale_clamp_core.sv
// Channel  Dir  Signals                       Content
// s        in   s_tvalid s_tready s_tdata     one accelerometer reading per word
// m        out  m_tvalid m_tready m_tdata     three tilt levels per block
// cfg      in   cfg_valid cfg_ready           register writes (index, data)
//
// A word that does not close a block is simply taken: sums and counter advance.
// After the word that closes a block, each axis runs two 20-step passes
// through the one shared serial divider.
// The result register parts the two sides: new words are taken while it waits.
// A closing word behind a waiting result stalls in the load step until m_tready.
// Reset clears sums and counter and loads sample_count 8 and sensitivity 1024.
`timescale 1ns / 1ps
module accel_average_scale_clamp_core
	import aasc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_DATA_W-1:0]   s_tdata,  // [15:0] x_word, [31:16] y_word, [47:32] z_word
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_DATA_W-1:0]   m_tdata,  // [5:0] x_level, [11:6] y_level, [17:12] z_level
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,  // 0 sample_count, 1 sensitivity
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	aasc_cmd_t cmd;
	aasc_sts_t sts;

	// Always ready; the user must keep the block idle when registers change, unchecked.
	assign cfg_ready = 1'b1;

	// Sequence accumulate, two divider passes per axis, and the output load.
	aasc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Hold sums, config, divider, level clamp and the result register.
	aasc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

### dv/tb_accel_average_scale_clamp_core.sv
`timescale 1ns / 1ps
module tb_accel_average_scale_clamp_core;
	import aasc_pkg::*;

	localparam int QUIET_CYCLES = 200;   // lets a closing word finish its divider passes
	localparam int HOLD_CYCLES  = 600;   // long receiver hold-off
	localparam int RAND_ITEMS   = 950;
	localparam int IDLE_PCT     = 38;

	// One accelerometer reading as it travels on s_tdata, x in the low bits.
	typedef struct packed {
		logic [WORD_W-1:0] z;
		logic [WORD_W-1:0] y;
		logic [WORD_W-1:0] x;
	} reading_t;

	// Three tilt levels as they travel on m_tdata, x in the low bits.
	typedef struct packed {
		logic [LEVEL_W-1:0] z;
		logic [LEVEL_W-1:0] y;
		logic [LEVEL_W-1:0] x;
	} tilt_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	accel_average_scale_clamp_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predictor state: register copies and the running block.
	logic [COUNT_W-1:0]       count_cfg = COUNT_RESET;
	logic [SENS_W-1:0]        sens_cfg  = SENS_RESET;
	logic signed [SUM_W-1:0]  sum_x = '0;
	logic signed [SUM_W-1:0]  sum_y = '0;
	logic signed [SUM_W-1:0]  sum_z = '0;
	logic [COUNT_W-1:0]       taken_cnt = '0;

	reading_t pending_readings[$];
	tilt_t    tilt_due[$];

	int  errors       = 0;
	int  rand_sent    = 0;
	int  idle_pct     = IDLE_PCT;
	logic in_fire     = 1'b0;
	logic s_taken     = 1'b0;
	logic hold_out    = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("[accel_average_scale_clamp_core] ERROR");
		$finish;
	end

	task automatic flag_mismatch(input string msg);
		errors++;
		if (errors <= 100)
			$display("%0t mismatch: %s", $time, msg);
	endtask

	// Sample is the upper 12 bits, sign-extended; the low nibble drops out.
	function automatic int axis_sample(input logic [WORD_W-1:0] w);
		logic signed [WORD_W-SAMPLE_SH-1:0] s;
		s = w[WORD_W-1:SAMPLE_SH];
		return int'(s);
	endfunction

	// Average, scale and clamp one axis; both divisions truncate toward zero.
	function automatic logic [LEVEL_W-1:0] tilt_level(input int sum, input int cnt,
			input int sens);
		int avg;
		int lvl;
		int zero_lvl;
		int max_lvl;
		zero_lvl = LEVEL_ZERO;
		max_lvl  = LEVEL_MAX;
		avg = sum / cnt;
		lvl = zero_lvl + (avg * 32) / sens;
		if (lvl < 0)
			lvl = 0;
		if (lvl > max_lvl)
			lvl = max_lvl;
		return lvl[LEVEL_W-1:0];
	endfunction

	// Fold one accepted word into the block; queue a result when it closes.
	task automatic take_reading(input logic [S_DATA_W-1:0] word);
		reading_t rd;
		tilt_t    lv;
		int       target;
		int       sens;
		rd = word;
		sum_x = sum_x + SUM_W'(axis_sample(rd.x));
		sum_y = sum_y + SUM_W'(axis_sample(rd.y));
		sum_z = sum_z + SUM_W'(axis_sample(rd.z));
		taken_cnt = taken_cnt + 1'b1;
		target = (count_cfg == 0) ? 1 : int'(count_cfg);
		sens   = (sens_cfg == 0) ? 1 : int'(sens_cfg);
		if (int'(taken_cnt) >= target) begin
			lv.x = tilt_level(int'(sum_x), int'(taken_cnt), sens);
			lv.y = tilt_level(int'(sum_y), int'(taken_cnt), sens);
			lv.z = tilt_level(int'(sum_z), int'(taken_cnt), sens);
			tilt_due.push_back(lv);
			sum_x = '0;
			sum_y = '0;
			sum_z = '0;
			taken_cnt = '0;
		end
	endtask

	// Sample both streams at the rising edge.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			in_fire = 1'b1;
			take_reading(s_tdata);
		end
		if (arst_n && m_tvalid && m_tready) begin
			tilt_t got;
			tilt_t want;
			got = m_tdata[3*LEVEL_W-1:0];
			if (tilt_due.size() == 0) begin
				flag_mismatch($sformatf("result with none pending: %h", m_tdata));
			end else begin
				want = tilt_due.pop_front();
				if (got.x != want.x)
					flag_mismatch($sformatf("x_level %0d, want %0d", got.x, want.x));
				if (got.y != want.y)
					flag_mismatch($sformatf("y_level %0d, want %0d", got.y, want.y));
				if (got.z != want.z)
					flag_mismatch($sformatf("z_level %0d, want %0d", got.z, want.z));
			end
		end
	end

	// Sender: drop the accepted word, hold an offered one, else maybe idle.
	always @(negedge clk) begin
		s_taken = in_fire;
		in_fire = 1'b0;
		if (s_taken)
			void'(pending_readings.pop_front());
		if (s_tvalid && !s_taken) begin
			// hold the word until it is taken
		end else if (pending_readings.size() != 0 && $urandom_range(99) >= idle_pct) begin
			s_tvalid <= 1'b1;
			s_tdata  <= pending_readings[0];
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// Receiver: random stalls, plus the long hold-off.
	always @(negedge clk)
		m_tready <= !hold_out && ($urandom_range(99) >= idle_pct);

	task automatic send_reading(input logic [WORD_W-1:0] x, input logic [WORD_W-1:0] y,
			input logic [WORD_W-1:0] z);
		reading_t rd;
		rd.x = x;
		rd.y = y;
		rd.z = z;
		pending_readings.push_back(rd);
	endtask

	// Mostly sensor-like words, with extremes and a few with a dirty nibble.
	function automatic logic [WORD_W-1:0] rand_word();
		logic [WORD_W-SAMPLE_SH-1:0] v;
		case ($urandom_range(9))
			0: return 16'h7FF0;
			1: return 16'h8000;
			2: return 16'($urandom);
			3, 4: begin
				v = 12'($urandom_range(64) - 32);
				return {v, 4'h0};
			end
			default: begin
				v = 12'($urandom);
				return {v, 4'h0};
			end
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_SAMPLE_COUNT)
			count_cfg = value[COUNT_W-1:0];
		else if (idx == CFG_SENSITIVITY)
			sens_cfg = value[SENS_W-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait for every word taken and every result back, then let the core settle.
	task automatic drain();
		while (pending_readings.size() != 0 || tilt_due.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	initial begin
		int cnt;
		int sens;
		int n;
		int r;
		int phase;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: full-scale x, full-scale negative y, small z.
		for (int i = 0; i < 8; i++)
			send_reading(16'h7FF0, 16'h8000, (i % 2) ? 16'h0010 : 16'hFFF0);
		drain();

		// One sample per block, unit sensitivity, dirty low nibble.
		write_reg(CFG_SAMPLE_COUNT, 1);
		write_reg(CFG_SENSITIVITY, 1);
		send_reading(16'hFFFF, 16'h0010, 16'h000F);
		send_reading(16'h7FFF, 16'h800F, 16'h0000);
		send_reading(16'h0000, 16'hFFFF, 16'h7FF0);
		drain();

		// A count of zero acts as one; odd sensitivity shows truncation.
		write_reg(CFG_SAMPLE_COUNT, 0);
		write_reg(CFG_SENSITIVITY, 3);
		send_reading(16'hFFF0, 16'h0010, 16'hFFE0);
		send_reading(16'h0020, 16'hFFD0, 16'h8000);
		drain();

		// Zero sensitivity, then the count lowered below what the block holds.
		write_reg(CFG_SAMPLE_COUNT, 8);
		write_reg(CFG_SENSITIVITY, 0);
		for (int i = 0; i < 5; i++)
			send_reading(16'h0010, 16'hFFF0, 16'h7FF0);
		drain();
		write_reg(CFG_SAMPLE_COUNT, 3);
		send_reading(16'h0000, 16'h0000, 16'h7FF0);
		drain();

		phase = 0;
		while (rand_sent < RAND_ITEMS) begin
			case (phase)
				0: begin
					cnt = 255;
					sens = 2047;
				end
				1: begin
					cnt = 1;
					sens = 1;
				end
				2: begin
					cnt = 2;
					sens = $urandom_range(1, 2047);
				end
				default: begin
					r = $urandom_range(99);
					if (r < 2)
						cnt = 0;
					else if (r < 60)
						cnt = $urandom_range(1, 8);
					else if (r < 85)
						cnt = $urandom_range(9, 40);
					else if (r < 95)
						cnt = $urandom_range(41, 254);
					else
						cnt = 255;
					r = $urandom_range(99);
					if (r < 3)
						sens = 0;
					else if (r < 18)
						sens = 1;
					else if (r < 28)
						sens = 2047;
					else if (r < 50)
						sens = $urandom_range(1, 64);
					else
						sens = $urandom_range(1, 2047);
				end
			endcase
			if (phase < 3 || $urandom_range(99) < 70)
				write_reg(CFG_SAMPLE_COUNT, cnt);
			if (phase < 3 || $urandom_range(99) < 70)
				write_reg(CFG_SENSITIVITY, sens);
			cnt = (count_cfg == 0) ? 1 : int'(count_cfg);
			n = (cnt <= 40) ? $urandom_range(8, 48) : cnt + $urandom_range(0, cnt / 4);

			// Hold the receiver so the result register fills and input stalls.
			if (phase == 1) begin
				n = 40;
				fork
					begin
						hold_out = 1'b1;
						repeat (HOLD_CYCLES) @(posedge clk);
						hold_out = 1'b0;
					end
				join_none
			end
			// Run one stretch with neither side idling.
			if (phase == 2) begin
				idle_pct = 0;
				n = 60;
			end
			// Stop at the item budget.
			if (n > RAND_ITEMS - rand_sent)
				n = RAND_ITEMS - rand_sent;

			for (int i = 0; i < n; i++)
				send_reading(rand_word(), rand_word(), rand_word());
			rand_sent += n;
			drain();
			idle_pct = IDLE_PCT;
			phase++;
		end

		drain();
		while (tilt_due.size() != 0) begin
			flag_mismatch("expected result never arrived");
			void'(tilt_due.pop_front());
		end
		if (errors == 0) begin
			$display("[accel_average_scale_clamp_core] OK");
		end else begin
			$display("[accel_average_scale_clamp_core] ERROR");
		end
		$finish;
	end

endmodule
